/* rtl/core/lru_key_value_cache_top_macros.svh */
// Assertion macros shared by the LRU key-value cache RTL.
// No dependencies; included by the modules that carry checks.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");
// Next-cycle implication.
`define LKVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");
// Invariant.
`define LKVC_ASSERT_INV(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_INV(label, clk, rst_n, expr)
`endif

`endif

/* rtl/core/lkvc_pkg.sv */
// Package for the LRU key-value cache: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W  = 5;
  localparam int LIM_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE   = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE    = '0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,  // get miss: state untouched
    ACT_HIT_GET = 3'd1,
    ACT_HIT_PUT = 3'd2,
    ACT_INSERT  = 3'd3,
    ACT_EVICT   = 3'd4
  } action_t;

  typedef struct packed {
    logic    lookup;  // capture request and compare results
    logic    update;  // apply update, launch result
    action_t act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_put;
    logic found;
    logic room;
  } dp_status_t;

endpackage

/* rtl/core/lkvc_ctrl.sv */
// Controller FSM of the LRU key-value cache.
// Depends on lkvc_pkg and the assertion macro header.
`include "lru_key_value_cache_top_macros.svh"

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.lookup = 1'b0;
    cmd.update = 1'b0;
    cmd.act    = ACT_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.lookup = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.found) begin
          cmd.act = status.op_put ? ACT_HIT_PUT : ACT_HIT_GET;
        end else if (status.op_put) begin
          cmd.act = status.room ? ACT_INSERT : ACT_EVICT;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r == ST_UPDATE);

  `LKVC_ASSERT_NXT(a_lookup_then_update, clk, rst_n, cmd.lookup, cmd.update)
  `LKVC_ASSERT_NXT(a_update_then_free, clk, rst_n, cmd.update, !busy)

endmodule

/* rtl/core/lkvc_datapath.sv */
// Datapath of the LRU key-value cache: entry storage, parallel key
// compare, recency ranks, config register, result register. Uses lkvc_pkg.
`include "lru_key_value_cache_top_macros.svh"

module lkvc_datapath
  import lkvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic              in_opcode,
  input  logic [DATA_W-1:0] in_key,
  input  logic [DATA_W-1:0] in_value,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_value
);

  // Entry storage
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [DATA_W-1:0]      key_r  [MAX_ENTRIES];
  logic [DATA_W-1:0]      val_r  [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank_r [MAX_ENTRIES];
  logic [CFG_W-1:0]       active_r;

  // Lookup stage registers
  logic              op_r;
  logic [DATA_W-1:0] req_key_r;
  logic [DATA_W-1:0] req_val_r;
  logic              found_r;
  logic              room_r;
  logic [IDX_W-1:0]  slot_r;
  logic [CNT_W-1:0]  old_rank_r;

  // Result registers
  logic              out_valid_r;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_value_r;

  // Compare logic
  logic [MAX_ENTRIES-1:0] match;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       victim_idx;
  logic [CNT_W-1:0]       count;
  logic [LIM_W-1:0]       limit;
  logic                   found;
  logic                   room;
  logic [IDX_W-1:0]       slot_sel;
  logic [CNT_W-1:0]       old_rank_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // Clamp to 1..MAX_ENTRIES
  always_comb begin
    limit = LIM_W'(active_r);
    if (limit == '0) begin
      limit = LIM_W'(1);
    end else if (limit > LIM_W'(MAX_ENTRIES)) begin
      limit = LIM_W'(MAX_ENTRIES);
    end
  end

  // Valid entries form a prefix, so the first free slot is also the count.
  always_comb begin
    count      = CNT_W'(MAX_ENTRIES);
    hit_idx    = '0;
    victim_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        count = CNT_W'(i);
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == in_key);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      // oldest entry holds rank count-1
      if (valid_r[i] && (CNT_W'(rank_r[i]) == count - CNT_W'(1))) begin
        victim_idx = IDX_W'(i);
      end
    end
    found = |match;
    room  = LIM_W'(count) < limit;
    if (found) begin
      slot_sel     = hit_idx;
      old_rank_sel = CNT_W'(rank_r[hit_idx]);
    end else if (room) begin
      slot_sel     = count[IDX_W-1:0];
      old_rank_sel = count;
    end else begin
      slot_sel     = victim_idx;
      old_rank_sel = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      op_r       <= in_opcode;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
      found_r    <= found;
      room_r     <= room;
      slot_r     <= slot_sel;
      old_rank_r <= old_rank_sel;
    end
  end

  assign status.op_put = (op_r == OP_PUT);
  assign status.found  = found_r;
  assign status.room   = room_r;

  // Control state: valid bits and ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update && (cmd.act != ACT_NONE)) begin
      if (cmd.act == ACT_INSERT) begin
        valid_r[slot_r] <= 1'b1;
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == slot_r) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (CNT_W'(rank_r[i]) < old_rank_r)) begin
          rank_r[i] <= rank_r[i] + IDX_W'(1);
        end
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      case (cmd.act)
        ACT_INSERT, ACT_EVICT: begin
          key_r[slot_r] <= req_key_r;
          val_r[slot_r] <= req_val_r;
        end
        ACT_HIT_PUT: begin
          val_r[slot_r] <= req_val_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r <= found_r;
      case (cmd.act)
        ACT_HIT_GET: out_value_r <= val_r[slot_r];
        ACT_NONE:    out_value_r <= MISS_VALUE;
        default:     out_value_r <= PUT_VALUE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  `LKVC_ASSERT_INV(a_valid_prefix, clk, rst_n,
    (valid_r & (valid_r + MAX_ENTRIES'(1))) == '0)
  `LKVC_ASSERT_NXT(a_update_gives_result, clk, rst_n, cmd.update, out_valid)

endmodule

/* rtl/core/lru_key_value_cache_top.sv */
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath and the macro header.
`include "lru_key_value_cache_top_macros.svh"

// Fully associative 16-entry key-value cache with least-recently-used
// replacement. A request (get or put) is transferred at a clock edge where
// start is high and busy is low. For each request, the key is
// compared against all entries in the transfer cycle, then ranks and
// entries are updated in the next cycle while busy is high. The result
// (out_hit, out_read_value) appears in the cycle after that, marked by a
// single-cycle out_valid strobe; the receiver cannot stall it, so it must
// take every result the cycle it is shown. A new request may be
// transferred in the same cycle a result is shown, but none is taken
// while busy is high. Get hit returns the stored value, get miss
// returns all ones; put returns zero and out_hit tells whether the key
// was already present. cfg_wdata sets the number of entries filled before
// eviction starts (0 acts as 1, above 16 as 16); write it only while idle.
// Reset clears all entries and sets the limit to 16; no clearing pass.
module lru_key_value_cache_top
  import lkvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [DATA_W-1:0] in_key,
  input  logic [DATA_W-1:0] in_value,
  // result
  output logic              out_valid,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_value,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lkvc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

  // results are single-cycle strobes, never back to back
  `LKVC_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  // a transfer always makes the block busy next cycle
  `LKVC_ASSERT_NXT(a_transfer_busy, clk, rst_n, start && !busy, busy)

endmodule
